@@ sv/ctc_greedy_decoder_assert.svh @@
// Assertion macros for the CTC greedy decoder.
// Included by the top level; depends on nothing else.
`ifndef CTC_GREEDY_DECODER_ASSERT_SVH
`define CTC_GREEDY_DECODER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CTC_ASSERT_NOW(label, ck, rn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CTC_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/ctc_pkg.sv @@
// Shared types and constants of the CTC greedy decoder.
// Used by the interfaces and every module of the block; depends on nothing.
`timescale 1ns / 1ps

package ctc_pkg;

	// Field widths.
	localparam int CLASS_W = 14;
	localparam int INDEX_W = 13;
	localparam int SCORE_W = 16;
	localparam int MEAN_W  = 10;
	localparam int TOTAL_W = 11;
	localparam int SUM_W   = 26;

	// Limits that the fixed field widths settle.
	localparam int MAX_CLASSES = 8192;
	localparam int MAX_STEPS   = 1024;

	// Configuration reset value.
	localparam logic [CLASS_W-1:0] CLASS_COUNT_RESET = CLASS_W'(97);

	// Mean scaling: sum * 1000, then the Q0.16 fraction is dropped before dividing.
	localparam int PERMILLE = 1000;
	localparam int FRAC_W   = 16;
	localparam int PROD_W   = SUM_W + 10;
	localparam int QUOT_W   = PROD_W - FRAC_W;
	localparam int BIT_W    = $clog2(QUOT_W);
	localparam logic [MEAN_W-1:0] MEAN_MAX = MEAN_W'(PERMILLE);

	// Default depth of the event queue between front and back.
	localparam int QUEUE_DEPTH = 4;

	// Result kinds.
	localparam logic KIND_TOKEN   = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	// One closed row that produces output.
	typedef struct packed {
		logic               emit;
		logic               seq_last;
		logic [INDEX_W-1:0] index;
		logic [SCORE_W-1:0] score;
		logic [SUM_W-1:0]   sum;
		logic [TOTAL_W-1:0] total;
	} ctc_event_t;

	// Queue status seen by both sides.
	typedef struct packed {
		logic full;
		logic empty;
	} ctc_fifo_stat_t;

	// Back-end sequencer states.
	typedef enum logic [1:0] {
		BK_IDLE,
		BK_MUL,
		BK_DIV,
		BK_SUM
	} back_state_t;

endpackage

@@ sv/ctc_if.sv @@
// Channel interfaces of the CTC greedy decoder: score input and result output.
// Depends on ctc_pkg for the field widths.
`timescale 1ns / 1ps

interface ctc_in_if;
	logic                         valid;
	logic                         ready;
	logic [ctc_pkg::SCORE_W-1:0]  class_score;
	logic                         row_end;
	logic                         seq_end;

	modport source (output valid, output class_score, output row_end, output seq_end,
		input ready);
	modport sink (input valid, input class_score, input row_end, input seq_end,
		output ready);
endinterface

interface ctc_out_if;
	logic                         valid;
	logic                         ready;
	logic                         kind;
	logic [ctc_pkg::INDEX_W-1:0]  token_index;
	logic [ctc_pkg::SCORE_W-1:0]  token_score;
	logic [ctc_pkg::MEAN_W-1:0]   mean_permille;
	logic [ctc_pkg::TOTAL_W-1:0]  token_total;
	logic                         is_last;

	modport source (output valid, output kind, output token_index, output token_score,
		output mean_permille, output token_total, output is_last, input ready);
	modport sink (input valid, input kind, input token_index, input token_score,
		input mean_permille, input token_total, input is_last, output ready);
endinterface

@@ sv/ctc_fifo.sv @@
// Small event queue that decouples the classifying front from the output back.
// Depends on ctc_pkg for the event and status types.
`timescale 1ns / 1ps

module ctc_fifo #(
	parameter int DEPTH = ctc_pkg::QUEUE_DEPTH
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  ctc_pkg::ctc_event_t     push_data,
	input  logic                    pop,
	output ctc_pkg::ctc_event_t     head,
	output ctc_pkg::ctc_fifo_stat_t stat
);
	import ctc_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	ctc_event_t       mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	// Storage write; entries need no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// Head entry and status.
	assign head       = mem_q[rd_ptr_q];
	assign stat.full  = (cnt_q == CNT_W'(DEPTH));
	assign stat.empty = (cnt_q == '0);

endmodule

@@ sv/ctc_front.sv @@
// Front end: takes scores, tracks the row maximum, closes rows and accumulates
// the token sum and count. Depends on ctc_pkg and the ctc_in_if interface.
`timescale 1ns / 1ps

module ctc_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [ctc_pkg::CLASS_W-1:0] cfg_wdata,
	ctc_in_if.sink                      scores,
	output logic                        push,
	output ctc_pkg::ctc_event_t         push_data,
	input  logic                        queue_full
);
	import ctc_pkg::*;

	logic [CLASS_W-1:0] class_count_q;
	logic [INDEX_W-1:0] counter_q;
	logic [SCORE_W-1:0] best_score_q;
	logic [INDEX_W-1:0] best_index_q;
	logic [INDEX_W-1:0] prev_index_q;
	logic               first_q;
	logic [SUM_W-1:0]   sum_q;
	logic [TOTAL_W-1:0] count_q;

	logic [CLASS_W-1:0] limit;
	logic               fire;
	logic               take;
	logic [SCORE_W-1:0] cur_score;
	logic [INDEX_W-1:0] cur_index;
	logic               close;
	logic               emit;
	logic               add;
	logic [SUM_W-1:0]   sum_next;
	logic [TOTAL_W-1:0] count_next;

	assign scores.ready = !queue_full;
	assign fire         = scores.valid && scores.ready;

	// Row tracking and close decision for the current score.
	always_comb begin
		if (class_count_q < CLASS_W'(2)) begin
			limit = CLASS_W'(2);
		end else if (class_count_q > CLASS_W'(MAX_CLASSES)) begin
			limit = CLASS_W'(MAX_CLASSES);
		end else begin
			limit = class_count_q;
		end

		take      = (counter_q == '0) || (scores.class_score > best_score_q);
		cur_score = take ? scores.class_score : best_score_q;
		cur_index = take ? counter_q : best_index_q;

		close = scores.row_end || scores.seq_end ||
			(({1'b0, counter_q} + CLASS_W'(1)) >= limit);

		// Blank and repeated indices make no token; the first step never repeats.
		emit = (cur_index != '0) && !(!first_q && (cur_index == prev_index_q));
		add  = emit && (count_q < TOTAL_W'(MAX_STEPS));

		sum_next   = add ? sum_q + SUM_W'(cur_score) : sum_q;
		count_next = add ? count_q + 1'b1 : count_q;

		push               = fire && close && (emit || scores.seq_end);
		push_data.emit     = emit;
		push_data.seq_last = scores.seq_end;
		push_data.index    = cur_index;
		push_data.score    = cur_score;
		push_data.sum      = sum_next;
		push_data.total    = count_next;
	end

	// Decoder state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			class_count_q <= CLASS_COUNT_RESET;
			counter_q     <= '0;
			best_score_q  <= '0;
			best_index_q  <= '0;
			prev_index_q  <= '0;
			first_q       <= 1'b1;
			sum_q         <= '0;
			count_q       <= '0;
		end else begin
			if (cfg_we) begin
				class_count_q <= cfg_wdata;
			end
			if (fire) begin
				if (!close) begin
					best_score_q <= cur_score;
					best_index_q <= cur_index;
					counter_q    <= counter_q + 1'b1;
				end else begin
					best_score_q <= '0;
					best_index_q <= '0;
					counter_q    <= '0;
					if (scores.seq_end) begin
						prev_index_q <= '0;
						first_q      <= 1'b1;
						sum_q        <= '0;
						count_q      <= '0;
					end else begin
						prev_index_q <= cur_index;
						first_q      <= 1'b0;
						sum_q        <= sum_next;
						count_q      <= count_next;
					end
				end
			end
		end
	end

endmodule

@@ sv/ctc_back.sv @@
// Back end: drains the event queue, sends tokens and computes the per-mille
// mean with a bit-serial divider. Depends on ctc_pkg and the ctc_out_if interface.
`timescale 1ns / 1ps

module ctc_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ctc_pkg::ctc_event_t     head,
	input  ctc_pkg::ctc_fifo_stat_t stat,
	output logic                    pop,
	ctc_out_if.source               results
);
	import ctc_pkg::*;

	back_state_t        state_q;
	back_state_t        state_d;
	logic [BIT_W-1:0]   bit_q;
	logic [SUM_W-1:0]   sum_q;
	logic [TOTAL_W-1:0] total_q;
	logic [QUOT_W-1:0]  quot_q;
	logic [TOTAL_W-1:0] rem_q;

	logic               out_valid_q;
	logic               kind_q;
	logic [INDEX_W-1:0] index_q;
	logic [SCORE_W-1:0] score_q;
	logic [MEAN_W-1:0]  mean_q;
	logic [TOTAL_W-1:0] out_total_q;
	logic               last_q;

	logic               out_free;
	logic               load_tok;
	logic               load_sum;
	logic [PROD_W-1:0]  prod;
	logic [TOTAL_W-1:0] divisor;
	logic [TOTAL_W:0]   trial;
	logic               ge;
	logic [TOTAL_W-1:0] step_rem;

	assign out_free = !out_valid_q || results.ready;

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and load strobes.
	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		load_tok = 1'b0;
		load_sum = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (!stat.empty && out_free) begin
					pop      = 1'b1;
					load_tok = head.emit;
					if (head.seq_last) begin
						state_d = BK_MUL;
					end
				end
			end
			BK_MUL: begin
				state_d = BK_DIV;
			end
			BK_DIV: begin
				if (bit_q == '0) begin
					state_d = BK_SUM;
				end
			end
			BK_SUM: begin
				if (out_free) begin
					load_sum = 1'b1;
					state_d  = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	// Scaling product and one restoring division step.
	always_comb begin
		prod     = PROD_W'(sum_q) * PROD_W'(PERMILLE);
		divisor  = (total_q == '0) ? TOTAL_W'(1) : total_q;
		trial    = {rem_q, quot_q[QUOT_W-1]};
		ge       = trial >= {1'b0, divisor};
		step_rem = ge ? TOTAL_W'(trial - {1'b0, divisor}) : trial[TOTAL_W-1:0];
	end

	// Division step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q <= '0;
		end else if (state_q == BK_MUL) begin
			bit_q <= BIT_W'(QUOT_W - 1);
		end else if (state_q == BK_DIV) begin
			bit_q <= bit_q - 1'b1;
		end
	end

	// Divider datapath; the quotient shifts in where the dividend shifts out.
	always_ff @(posedge clk) begin
		if (pop) begin
			sum_q   <= head.sum;
			total_q <= head.total;
		end
		if (state_q == BK_MUL) begin
			quot_q <= prod[PROD_W-1 -: QUOT_W];
			rem_q  <= '0;
		end else if (state_q == BK_DIV) begin
			quot_q <= {quot_q[QUOT_W-2:0], ge};
			rem_q  <= step_rem;
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_tok || load_sum) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (load_tok) begin
			kind_q      <= KIND_TOKEN;
			index_q     <= head.index;
			score_q     <= head.score;
			mean_q      <= '0;
			out_total_q <= '0;
			last_q      <= !head.seq_last;
		end else if (load_sum) begin
			kind_q      <= KIND_SUMMARY;
			index_q     <= '0;
			score_q     <= '0;
			mean_q      <= quot_q[MEAN_W-1:0];
			out_total_q <= total_q;
			last_q      <= 1'b1;
		end
	end

	assign results.valid         = out_valid_q;
	assign results.kind          = kind_q;
	assign results.token_index   = index_q;
	assign results.token_score   = score_q;
	assign results.mean_permille = mean_q;
	assign results.token_total   = out_total_q;
	assign results.is_last       = last_q;

endmodule

@@ sv/ctc_greedy_decoder.sv @@
// Top level of the CTC greedy decoder: front end, event queue and back end.
// Depends on ctc_pkg, ctc_if, ctc_fifo, ctc_front, ctc_back and the assertion header.
//
// Usage:
//   scores  - one class score per transaction, class 0 first; row_end marks the
//             last score of a time step and seq_end the last step of a sequence.
//   results - token transactions (kind 0) and one summary per sequence (kind 1)
//             with the per-mille mean token score and the token count.
//   cfg_we / cfg_wdata - writes class_count; write only while the block is idle.
// Throughput: one score per cycle while the queue has room. A row that gives a
// token or ends a sequence puts one event into a queue of FIFO_DEPTH entries; the
// back end takes the next event whenever the output register is free, but a
// summary takes the pop, a product step, 20 divider steps at one quotient bit per
// cycle and a load, and no event is taken before that load. A token passes from
// its closing score through the event queue and the output register. Scores are
// refused only while the queue is full.
// Reset: asynchronous, clears row state, sums and queue; class_count returns to 97.
// A stalled receiver holds the output register; the queue absorbs closing rows
// until it fills, after which scores.ready drops.
`timescale 1ns / 1ps

module ctc_greedy_decoder #(
	parameter int FIFO_DEPTH = ctc_pkg::QUEUE_DEPTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [ctc_pkg::CLASS_W-1:0] cfg_wdata,
	ctc_in_if.sink                      scores,
	ctc_out_if.source                   results
);
	import ctc_pkg::*;

	`include "ctc_greedy_decoder_assert.svh"

	logic           q_push;
	logic           q_pop;
	ctc_event_t     q_in;
	ctc_event_t     q_head;
	ctc_fifo_stat_t q_stat;
	logic           summary_pop;
	logic           summary_out;
	logic           summary_ok;

	// Classifying front end.
	ctc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.scores     (scores),
		.push       (q_push),
		.push_data  (q_in),
		.queue_full (q_stat.full)
	);

	// Event queue.
	ctc_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.pop       (q_pop),
		.head      (q_head),
		.stat      (q_stat)
	);

	// Output back end.
	ctc_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (q_head),
		.stat    (q_stat),
		.pop     (q_pop),
		.results (results)
	);

	// Terms that the checks below share.
	assign summary_pop = q_pop && q_head.seq_last;
	assign summary_out = results.valid && (results.kind == KIND_SUMMARY);
	assign summary_ok  = results.is_last && (results.mean_permille <= MEAN_MAX);

	// Queue discipline between the two halves.
	`CTC_ASSERT_NOW(a_no_push_full, clk, arst_n, q_push, !q_stat.full, "push into full queue")
	`CTC_ASSERT_NOW(a_no_pop_empty, clk, arst_n, q_pop, !q_stat.empty, "pop from empty queue")
	// A summary occupies the divider, so no event is taken in the next cycle.
	`CTC_ASSERT_NEXT(a_div_busy, clk, arst_n, summary_pop, !q_pop, "event taken while dividing")
	// Summaries close the transaction group and carry a mean within range.
	`CTC_ASSERT_NOW(a_summary_ok, clk, arst_n, summary_out, summary_ok, "malformed summary")

endmodule

@@ tb/tb_ctc_greedy_decoder.sv @@
// Self-checking testbench for the CTC greedy decoder: scores in, tokens and summaries out.
// Depends on ctc_pkg, the ctc_in_if/ctc_out_if interfaces and the ctc_greedy_decoder RTL.
`timescale 1ns / 1ps

module tb_ctc_greedy_decoder;

	localparam int RUN_LIMIT     = 500000;
	localparam int DRAIN_LIMIT   = 50000;
	localparam int SETTLE_CYCLES = 40;
	localparam int IDLE_PERCENT  = 23;
	localparam int HOLD_CYCLES   = 300;
	localparam int PHASE_ITEMS   = 20;

	// One result transaction as the decoder should produce it.
	typedef struct packed {
		logic                         kind;
		logic [ctc_pkg::INDEX_W-1:0]  token_index;
		logic [ctc_pkg::SCORE_W-1:0]  token_score;
		logic [ctc_pkg::MEAN_W-1:0]   mean_permille;
		logic [ctc_pkg::TOTAL_W-1:0]  token_total;
		logic                         is_last;
	} token_result_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [ctc_pkg::CLASS_W-1:0] cfg_wdata;

	ctc_in_if  scores_if();
	ctc_out_if results_if();

	ctc_greedy_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.scores    (scores_if),
		.results   (results_if)
	);

	// Decoder state as the testbench tracks it.
	logic [ctc_pkg::CLASS_W-1:0] class_count_cfg = ctc_pkg::CLASS_COUNT_RESET;
	logic [ctc_pkg::INDEX_W-1:0] row_pos         = '0;
	logic [ctc_pkg::SCORE_W-1:0] row_best_score  = '0;
	logic [ctc_pkg::INDEX_W-1:0] row_best_index  = '0;
	logic [ctc_pkg::INDEX_W-1:0] last_index      = '0;
	logic                        at_seq_start    = 1'b1;
	logic [ctc_pkg::SUM_W-1:0]   seq_score_sum   = '0;
	logic [ctc_pkg::TOTAL_W-1:0] seq_tokens      = '0;

	token_result_t pending_results[$];

	int  errors      = 0;
	int  cycle_count = 0;
	int  rx_hold     = 0;
	bit  src_idle_on = 1'b1;
	bit  snk_idle_on = 1'b1;

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Works out the results that one accepted score transaction causes.
	task automatic decode_score(input logic [ctc_pkg::SCORE_W-1:0] sc, input logic re,
		input logic se);
		int                lim;
		logic              emit;
		token_result_t     res;
		longint unsigned   divisor;
		longint unsigned   product;
		lim = int'(class_count_cfg);
		if (lim < 2)
			lim = 2;
		if (lim > ctc_pkg::MAX_CLASSES)
			lim = ctc_pkg::MAX_CLASSES;

		// Running maximum; the first occurrence keeps the index.
		if (row_pos == '0 || sc > row_best_score) begin
			row_best_score = sc;
			row_best_index = row_pos;
		end

		if (!(re || se || int'(row_pos) + 1 >= lim)) begin
			row_pos = row_pos + 1'b1;
			return;
		end

		// Row closed: blanks and repeats of the previous step give no token.
		emit = (row_best_index != '0) && !(!at_seq_start && row_best_index == last_index);
		if (emit) begin
			if (seq_tokens < ctc_pkg::MAX_STEPS) begin
				seq_score_sum = seq_score_sum + row_best_score;
				seq_tokens    = seq_tokens + 1'b1;
			end
			res             = '0;
			res.kind        = ctc_pkg::KIND_TOKEN;
			res.token_index = row_best_index;
			res.token_score = row_best_score;
			res.is_last     = !se;
			pending_results.insert(pending_results.size(), res);
		end
		last_index   = row_best_index;
		at_seq_start = 1'b0;
		row_pos      = '0;

		// Sequence closed: mean token score in per-mille, then start over.
		if (se) begin
			divisor = (seq_tokens == '0) ? 64'd1 : 64'(seq_tokens);
			divisor = divisor << ctc_pkg::FRAC_W;
			product = 64'(seq_score_sum) * ctc_pkg::PERMILLE;
			res               = '0;
			res.kind          = ctc_pkg::KIND_SUMMARY;
			res.mean_permille = ctc_pkg::MEAN_W'(product / divisor);
			res.token_total   = seq_tokens;
			res.is_last       = 1'b1;
			pending_results.insert(pending_results.size(), res);
			seq_score_sum = '0;
			seq_tokens    = '0;
			at_seq_start  = 1'b1;
			last_index    = '0;
		end
		row_best_score = '0;
		row_best_index = '0;
	endtask

	// Offers one score transaction and waits until the decoder takes it.
	// Valid stays high afterward so that back-to-back items need no extra edge.
	task automatic send_score(input logic [ctc_pkg::SCORE_W-1:0] sc, input logic re,
		input logic se);
		while (src_idle_on && $urandom_range(99) < IDLE_PERCENT) begin
			scores_if.valid <= 1'b0;
			@(posedge clk);
		end
		scores_if.valid       <= 1'b1;
		scores_if.class_score <= sc;
		scores_if.row_end     <= re;
		scores_if.seq_end     <= se;
		@(posedge clk);
		while (!scores_if.ready)
			@(posedge clk);
		decode_score(sc, re, se);
	endtask

	// Sends one time step: the peak score at peak_at, the others drawn up to ceiling, or all random if noisy.
	// Without closed the last score carries no row end; last_row adds the sequence end.
	task automatic send_row(input int len, input int peak_at,
		input logic [ctc_pkg::SCORE_W-1:0] peak, input logic [ctc_pkg::SCORE_W-1:0] ceiling,
		input bit closed, input bit last_row, input bit noisy);
		logic [ctc_pkg::SCORE_W-1:0] sc;
		for (int k = 0; k < len; k++) begin
			if (noisy)
				sc = 16'($urandom_range(65535));
			else if (k == peak_at)
				sc = peak;
			else
				sc = 16'($urandom_range(int'(ceiling)));
			send_score(sc, closed && k == len - 1, last_row && k == len - 1);
		end
	endtask

	// Drops valid and waits until every expected result has arrived or the DRAIN_LIMIT
	// guard runs out, then lets the decoder settle.
	task automatic wait_drained();
		int guard;
		guard = 0;
		scores_if.valid <= 1'b0;
		while (pending_results.size() != 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes class_count once the decoder is idle.
	task automatic set_class_count(input logic [ctc_pkg::CLASS_W-1:0] value);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we          <= 1'b0;
		class_count_cfg  = value;
	endtask

	task automatic check_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	// Result monitor: checks each accepted transaction and drives ready.
	initial begin : result_monitor
		token_result_t got;
		token_result_t want;
		results_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && results_if.valid && results_if.ready) begin
				got.kind          = results_if.kind;
				got.token_index   = results_if.token_index;
				got.token_score   = results_if.token_score;
				got.mean_permille = results_if.mean_permille;
				got.token_total   = results_if.token_total;
				got.is_last       = results_if.is_last;
				if (pending_results.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, expected none, actual kind %0d index %0d",
						$time, got.kind, got.token_index);
					$display("  score %0d mean %0d total %0d last %0d", got.token_score,
						got.mean_permille, got.token_total, got.is_last);
				end else begin
					want = pending_results.pop_front();
					check_field("kind", want.kind, got.kind);
					check_field("token_index", want.token_index, got.token_index);
					check_field("token_score", want.token_score, got.token_score);
					check_field("mean_permille", want.mean_permille, got.mean_permille);
					check_field("token_total", want.token_total, got.token_total);
					check_field("is_last", want.is_last, got.is_last);
				end
			end
			// A requested hold-off wins over the random idling.
			if (rx_hold > 0) begin
				rx_hold--;
				results_if.ready <= 1'b0;
			end else begin
				results_if.ready <= !(snk_idle_on && $urandom_range(99) < IDLE_PERCENT);
			end
		end
	end

	// Reset value of class_count: a full row of 97 closes by itself.
	task automatic test_default_class_count();
		send_row(97, 96, 16'hFFFF, 16'd60000, 1'b0, 1'b0, 1'b0);
		send_score(16'd20, 1'b0, 1'b0);
		send_score(16'd10, 1'b1, 1'b1);
		wait_drained();
	endtask

	// Ties, blanks, repeats, forced row end, sequence end alone, empty sequence.
	task automatic test_row_rules();
		set_class_count(14'd8);
		// The first of two equal maxima wins.
		send_score(16'd0, 1'b0, 1'b0);
		send_score(16'hFFFF, 1'b0, 1'b0);
		send_score(16'hFFFF, 1'b1, 1'b0);
		send_score(16'd7, 1'b0, 1'b0);
		send_score(16'd3, 1'b0, 1'b0);
		send_score(16'd9, 1'b0, 1'b0);
		send_score(16'd9, 1'b0, 1'b0);
		send_score(16'd2, 1'b1, 1'b0);
		// Same index as the step before is suppressed.
		send_score(16'd1, 1'b0, 1'b0);
		send_score(16'd5, 1'b0, 1'b0);
		send_score(16'd50, 1'b1, 1'b0);
		// A blank step, after which the same index counts again.
		send_score(16'hFFFF, 1'b0, 1'b0);
		send_score(16'd0, 1'b1, 1'b0);
		send_score(16'd0, 1'b0, 1'b0);
		send_score(16'd0, 1'b0, 1'b0);
		send_score(16'd9, 1'b1, 1'b0);
		// A full row with no row end closes on its own.
		send_row(8, 7, 16'd1, 16'd0, 1'b0, 1'b0, 1'b0);
		// Sequence end without row end gives a token and then the summary.
		send_score(16'd3, 1'b0, 1'b0);
		send_score(16'd40, 1'b0, 1'b1);
		// A sequence with no tokens reports a zero mean.
		send_score(16'd12, 1'b1, 1'b1);
		send_score(16'd0, 1'b0, 1'b0);
		send_score(16'h8000, 1'b1, 1'b1);
		wait_drained();
	endtask

	// Register extremes: values below 2 and above the class limit are clamped.
	task automatic test_class_count_limits();
		set_class_count(14'd0);
		send_row(2, 1, 16'd500, 16'd499, 1'b0, 1'b0, 1'b0);
		send_row(2, 0, 16'd500, 16'd499, 1'b0, 1'b0, 1'b0);
		send_row(2, 1, 16'd700, 16'd700, 1'b0, 1'b1, 1'b0);
		set_class_count(14'd1);
		send_row(2, 1, 16'd300, 16'd10, 1'b0, 1'b0, 1'b0);
		send_row(2, 1, 16'd300, 16'd10, 1'b0, 1'b1, 1'b0);
		set_class_count(14'd2);
		send_row(2, 1, 16'd900, 16'd100, 1'b0, 1'b0, 1'b0);
		send_row(1, 0, 16'd4, 16'd4, 1'b1, 1'b1, 1'b0);
		set_class_count(14'd8192);
		send_row(5, 4, 16'd1234, 16'd1000, 1'b1, 1'b0, 1'b0);
		send_row(12, 3, 16'hFFFF, 16'hFFFE, 1'b1, 1'b1, 1'b0);
		// The largest register value clamps to 8192 classes, so this row needs its row end.
		set_class_count(14'h3FFF);
		send_row(30, 29, 16'hFFFF, 16'd60000, 1'b1, 1'b0, 1'b0);
		send_row(3, 2, 16'd7, 16'd7, 1'b1, 1'b1, 1'b0);
		wait_drained();
	endtask

	// The receiver holds off while the sender keeps going, so the event queue
	// fills and scores.ready drops.
	task automatic test_backpressure();
		set_class_count(14'd3);
		src_idle_on = 1'b0;
		snk_idle_on = 1'b0;
		rx_hold     = HOLD_CYCLES;
		for (int p = 0; p < 30; p++) begin
			send_row(2, 1, 16'(100 + p), 16'd99, 1'b1, 1'b0, 1'b0);
			send_row(3, 2, 16'(200 + p), 16'd199, 1'b0, p == 29, 1'b0);
		end
		wait_drained();
		src_idle_on = 1'b1;
		snk_idle_on = 1'b1;
	endtask

	// A long sequence of alternating tokens with random peaks, sent without gaps.
	task automatic test_long_sequence();
		logic [ctc_pkg::SCORE_W-1:0] peak;
		set_class_count(14'd3);
		src_idle_on = 1'b0;
		snk_idle_on = 1'b0;
		for (int p = 0; p < 10; p++) begin
			peak = 16'($urandom_range(65535));
			send_row(2, 1, peak, peak, 1'b1, 1'b0, 1'b0);
			peak = 16'($urandom_range(65535));
			send_row(3, 2, peak, peak, 1'b0, 1'b0, 1'b0);
		end
		send_row(2, 1, 16'hFFFF, 16'd10, 1'b1, 1'b1, 1'b0);
		wait_drained();
		src_idle_on = 1'b1;
		snk_idle_on = 1'b1;
	endtask

	// Random sequences under several class counts, mostly well-formed rows.
	task automatic test_random_sequences();
		int lim;
		int rows;
		int len;
		int peak_at;
		int prev_peak;
		int sent;
		int pick;
		bit forced;
		bit last_row;
		bit closed;
		bit noisy;
		logic [ctc_pkg::SCORE_W-1:0] peak;
		logic [ctc_pkg::CLASS_W-1:0] setting;
		prev_peak = 1;
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: setting = 14'd5;
				1: setting = 14'd2;
				2: setting = 14'd13;
				3: setting = 14'd0;
				4: setting = 14'd97;
				default: setting = 14'd40;
			endcase
			set_class_count(setting);
			lim = (setting < 2) ? 2 : int'(setting);
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				rows = $urandom_range(1, 8);
				for (int r = 0; r < rows; r++) begin
					noisy    = $urandom_range(99) < 20;
					forced   = lim <= 40 && $urandom_range(99) < 15;
					len      = forced ? lim : $urandom_range(1, lim < 10 ? lim : 10);
					last_row = r == rows - 1;
					// Some sequences end without a row end on their last score.
					closed   = !forced && !(last_row && $urandom_range(99) < 15);
					pick     = $urandom_range(99);
					if (pick < 25 && prev_peak < len)
						peak_at = prev_peak;
					else if (pick < 45)
						peak_at = 0;
					else
						peak_at = $urandom_range(len - 1);
					pick = $urandom_range(7);
					if (pick == 0)
						peak = 16'hFFFF;
					else if (pick == 1)
						peak = 16'($urandom_range(15));
					else
						peak = 16'($urandom_range(65535));
					send_row(len, peak_at, peak, peak, closed, last_row, noisy);
					prev_peak = peak_at;
					sent += len;
				end
			end
		end
	endtask

	// Main sequence: reset, the tests in turn, then the verdict.
	initial begin
		arst_n                = 1'b0;
		cfg_we                = 1'b0;
		cfg_wdata             = '0;
		scores_if.valid       = 1'b0;
		scores_if.class_score = '0;
		scores_if.row_end     = 1'b0;
		scores_if.seq_end     = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_class_count();
		test_row_rules();
		test_class_count_limits();
		test_backpressure();
		test_long_sequence();
		test_random_sequences();
		wait_drained();

		if (pending_results.size() != 0) begin
			errors += pending_results.size();
			$display("%0t: %0d expected results never arrived", $time, pending_results.size());
		end
		if (errors == 0)
			$display("ctc_greedy_decoder regression: pass");
		else
			$display("ctc_greedy_decoder regression: fail");
		$finish;
	end

	// Watchdog: a hung handshake ends the run.
	initial begin : watchdog
		while (cycle_count < RUN_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("ctc_greedy_decoder regression: fail");
		$finish;
	end

endmodule
